/* sv/json_pretty_printer_defines.svh */
// Assertion macros shared by the JSON pretty printer RTL.
`ifndef JSON_PRETTY_PRINTER_DEFINES_SVH
`define JSON_PRETTY_PRINTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/jpp_pkg.sv */
// Shared types and character constants for the JSON pretty printer.
package jpp_pkg;

   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;

   localparam int unsigned PHASE_COUNT = 5;

   // Emission phases of one transaction, in output order.
   typedef enum logic [2:0] {
      PH_NL_A = 3'd0,
      PH_SP_A = 3'd1,
      PH_BYTE = 3'd2,
      PH_NL_B = 3'd3,
      PH_SP_B = 3'd4
   } phase_type;

   typedef struct packed {
      logic      load;
      logic      emit;
      phase_type phase;
      logic      last;
   } jpp_cmd_type;

   typedef struct packed {
      logic                     out_free;
      logic [PHASE_COUNT-1:0]   new_has;
      logic [PHASE_COUNT-1:0]   plan_has;
      logic                     sp_a_more;
      logic                     sp_b_more;
   } jpp_status_type;

endpackage

/* sv/jpp_ctrl.sv */
// Sequencer that walks the emission phases of one transaction.
module jpp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  jpp_pkg::jpp_status_type status,
   output jpp_pkg::jpp_cmd_type    cmd
);
   import jpp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NL_A,
      ST_SP_A,
      ST_BYTE,
      ST_NL_B,
      ST_SP_B
   } state_type;

   state_type state_ff, state_in;
   logic [PHASE_COUNT-1:0] later_mask;
   logic more;

   function automatic state_type first_phase(input logic [PHASE_COUNT-1:0] has);
      state_type s;
      if (has[PH_NL_A]) begin
         s = ST_NL_A;
      end else if (has[PH_SP_A]) begin
         s = ST_SP_A;
      end else if (has[PH_BYTE]) begin
         s = ST_BYTE;
      end else if (has[PH_NL_B]) begin
         s = ST_NL_B;
      end else if (has[PH_SP_B]) begin
         s = ST_SP_B;
      end else begin
         s = ST_IDLE;
      end
      return s;
   endfunction

   always_comb begin
      cmd        = '0;
      cmd.phase  = PH_NL_A;
      later_mask = '0;
      more       = 1'b0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            if (req_tvalid) begin
               state_in = first_phase(status.new_has);
            end
         end
         ST_NL_A: begin
            cmd.phase  = PH_NL_A;
            later_mask = 5'b11110;
         end
         ST_SP_A: begin
            cmd.phase  = PH_SP_A;
            later_mask = 5'b11100;
            more       = status.sp_a_more;
         end
         ST_BYTE: begin
            cmd.phase  = PH_BYTE;
            later_mask = 5'b11000;
         end
         ST_NL_B: begin
            cmd.phase  = PH_NL_B;
            later_mask = 5'b10000;
         end
         ST_SP_B: begin
            cmd.phase  = PH_SP_B;
            later_mask = 5'b00000;
            more       = status.sp_b_more;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff != ST_IDLE) begin
         cmd.emit = status.out_free;
         cmd.last = !more && ((status.plan_has & later_mask) == '0);
         if (status.out_free && !more) begin
            state_in = first_phase(status.plan_has & later_mask);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/jpp_datapath.sv */
// Formatter state, per-transaction emission plan and result register.
module jpp_datapath #(
   parameter int MAX_DEPTH = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              in_byte,
   input  logic                    chunk_start,
   input  logic                    chunk_end,
   input  jpp_pkg::jpp_cmd_type    cmd,
   output jpp_pkg::jpp_status_type status,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [7:0]              out_byte,
   output logic                    out_last,
   output logic                    out_overflow
);
   import jpp_pkg::*;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_NEWLINE = 2'd1,
      KIND_SPACE   = 2'd2,
      KIND_OTHER   = 2'd3
   } kind_type;

   localparam logic [3:0] MaxDepth = 4'(MAX_DEPTH);

   // formatter state
   logic       in_string_ff, in_string_in;
   logic       after_escape_ff, after_escape_in;
   logic [3:0] depth_ff, depth_in;
   logic [4:0] pending_ff, pending_in;
   kind_type   kind_ff, kind_in;
   logic       overflow_ff, overflow_in;

   // emission plan
   logic       nl_a_ff, nl_a_in;
   logic [4:0] sp_a_ff, sp_a_in;
   logic       has_byte_ff, has_byte_in;
   logic [7:0] byte_ff;
   logic       nl_b_ff, nl_b_in;
   logic [4:0] sp_b_ff, sp_b_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff;
   logic       out_overflow_ff;

   logic       eff_string, eff_escape, eff_overflow;
   logic [3:0] eff_depth;
   logic [4:0] eff_pending, pend_mid;
   kind_type   eff_kind;
   logic       is_blank;

   function automatic kind_type kind_of(input logic [7:0] b);
      kind_type k;
      if (b == CHAR_NEWLINE) begin
         k = KIND_NEWLINE;
      end else if (b == CHAR_SPACE) begin
         k = KIND_SPACE;
      end else begin
         k = KIND_OTHER;
      end
      return k;
   endfunction

   always_comb begin
      eff_string   = chunk_start ? 1'b0 : in_string_ff;
      eff_escape   = chunk_start ? 1'b0 : after_escape_ff;
      eff_depth    = chunk_start ? '0 : depth_ff;
      eff_pending  = chunk_start ? '0 : pending_ff;
      eff_kind     = chunk_start ? KIND_NONE : kind_ff;
      eff_overflow = chunk_start ? 1'b0 : overflow_ff;
      is_blank     = (in_byte == CHAR_SPACE) ||
                     ((in_byte >= CHAR_TAB) && (in_byte <= CHAR_CR));

      nl_a_in         = 1'b0;
      sp_a_in         = '0;
      has_byte_in     = 1'b0;
      nl_b_in         = 1'b0;
      pend_mid        = eff_pending;
      depth_in        = eff_depth;
      in_string_in    = eff_string;
      after_escape_in = eff_escape;
      overflow_in     = eff_overflow;

      if (eff_string) begin
         sp_a_in     = eff_pending;
         has_byte_in = 1'b1;
         pend_mid    = '0;
         if (eff_escape) begin
            after_escape_in = 1'b0;
         end else if (in_byte == CHAR_BACKSLASH) begin
            after_escape_in = 1'b1;
         end else if (in_byte == CHAR_QUOTE) begin
            in_string_in = 1'b0;
         end
      end else if (in_byte == CHAR_QUOTE) begin
         sp_a_in         = eff_pending;
         has_byte_in     = 1'b1;
         pend_mid        = '0;
         in_string_in    = 1'b1;
         after_escape_in = 1'b0;
      end else if (in_byte == CHAR_LBRACE || in_byte == CHAR_LBRACKET) begin
         sp_a_in     = eff_pending;
         has_byte_in = 1'b1;
         nl_b_in     = 1'b1;
         if (eff_depth >= MaxDepth) begin
            depth_in    = MaxDepth;
            overflow_in = 1'b1;
         end else begin
            depth_in = eff_depth + 4'd1;
         end
         pend_mid = {depth_in, 1'b0};
      end else if (in_byte == CHAR_RBRACE || in_byte == CHAR_RBRACKET) begin
         nl_a_in     = (eff_kind != KIND_NONE) && (eff_kind != KIND_NEWLINE);
         depth_in    = (eff_depth != '0) ? eff_depth - 4'd1 : eff_depth;
         sp_a_in     = {depth_in, 1'b0};
         has_byte_in = 1'b1;
         pend_mid    = '0;
      end else if (in_byte == CHAR_COMMA) begin
         sp_a_in     = eff_pending;
         has_byte_in = 1'b1;
         nl_b_in     = 1'b1;
         pend_mid    = {eff_depth, 1'b0};
      end else if (in_byte == CHAR_COLON) begin
         sp_a_in     = eff_pending;
         has_byte_in = 1'b1;
         pend_mid    = 5'd1;
      end else if (!is_blank) begin
         sp_a_in     = eff_pending;
         has_byte_in = 1'b1;
         pend_mid    = '0;
      end

      sp_b_in    = chunk_end ? pend_mid : '0;
      pending_in = chunk_end ? '0 : pend_mid;

      // kind of the last byte this transaction will emit
      if (sp_b_in != '0) begin
         kind_in = KIND_SPACE;
      end else if (nl_b_in) begin
         kind_in = KIND_NEWLINE;
      end else if (has_byte_in) begin
         kind_in = kind_of(in_byte);
      end else if (sp_a_in != '0) begin
         kind_in = KIND_SPACE;
      end else if (nl_a_in) begin
         kind_in = KIND_NEWLINE;
      end else begin
         kind_in = eff_kind;
      end
   end

   always_comb begin
      status.out_free  = !out_valid_ff || out_ready;
      status.new_has   = {sp_b_in != '0, nl_b_in, has_byte_in, sp_a_in != '0, nl_a_in};
      status.plan_has  = {sp_b_ff != '0, nl_b_ff, has_byte_ff, sp_a_ff != '0, nl_a_ff};
      status.sp_a_more = sp_a_ff > 5'd1;
      status.sp_b_more = sp_b_ff > 5'd1;

      case (cmd.phase)
         PH_BYTE:          out_byte_in = byte_ff;
         PH_NL_A, PH_NL_B: out_byte_in = CHAR_NEWLINE;
         default:          out_byte_in = CHAR_SPACE;
      endcase

      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_string_ff    <= 1'b0;
         after_escape_ff <= 1'b0;
         depth_ff        <= '0;
         pending_ff      <= '0;
         kind_ff         <= KIND_NONE;
         overflow_ff     <= 1'b0;
         nl_a_ff         <= 1'b0;
         sp_a_ff         <= '0;
         has_byte_ff     <= 1'b0;
         nl_b_ff         <= 1'b0;
         sp_b_ff         <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (cmd.load) begin
            in_string_ff    <= in_string_in;
            after_escape_ff <= after_escape_in;
            depth_ff        <= depth_in;
            pending_ff      <= pending_in;
            kind_ff         <= kind_in;
            overflow_ff     <= overflow_in;
            nl_a_ff         <= nl_a_in;
            sp_a_ff         <= sp_a_in;
            has_byte_ff     <= has_byte_in;
            nl_b_ff         <= nl_b_in;
            sp_b_ff         <= sp_b_in;
         end else if (cmd.emit) begin
            case (cmd.phase)
               PH_NL_A: nl_a_ff     <= 1'b0;
               PH_SP_A: sp_a_ff     <= sp_a_ff - 5'd1;
               PH_BYTE: has_byte_ff <= 1'b0;
               PH_NL_B: nl_b_ff     <= 1'b0;
               default: sp_b_ff     <= sp_b_ff - 5'd1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= in_byte;
      end
      if (cmd.emit) begin
         out_byte_ff     <= out_byte_in;
         out_last_ff     <= cmd.last;
         out_overflow_ff <= overflow_ff;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_byte     = out_byte_ff;
   assign out_last     = out_last_ff;
   assign out_overflow = out_overflow_ff;

endmodule

/* sv/json_pretty_printer.sv */
// Top level of the streaming JSON pretty printer.
//
//   channel   dir   tdata            tuser            tlast
//   req_      in    in_byte [7:0]    chunk_start      chunk_end
//   rsp_      out   out_byte [7:0]   depth_overflow   run_last
//
// After an input byte is accepted, the emission sequencer issues its result
// bytes into the result register, one byte a cycle while that register is
// free, and the block takes no new byte until the last result is issued.
// A byte that causes no result leaves the block ready for the next byte.
// Reset (synchronous, active high) clears all formatter state and the
// result valid flag; chunk_start clears the formatter state for its byte.
// A stall on rsp_ holds the sequencer; req_tready stays low until the
// last result of the current transaction has entered the result register.
`include "json_pretty_printer_defines.svh"

module json_pretty_printer #(
   parameter int MAX_DEPTH = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] chunk_start
   input  logic       req_tlast,   // chunk_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] depth_overflow
   output logic       rsp_tlast    // run_last
);
   import jpp_pkg::*;

   jpp_cmd_type    cmd;
   jpp_status_type status;

   // Walk the plan: newline, indent, byte, newline, flushed spaces.
   jpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold formatter state, build the plan on accept, drive the result register.
   jpp_datapath #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .in_byte      (req_tdata),
      .chunk_start  (req_tuser),
      .chunk_end    (req_tlast),
      .cmd          (cmd),
      .status       (status),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_byte     (rsp_tdata),
      .out_last     (rsp_tlast),
      .out_overflow (rsp_tuser)
   );

   // Never overwrite a result that has not been taken.
   `JPP_ASSERT_NOW(a_emit_into_free, clock, reset, cmd.emit, status.out_free, "emit into full result register")
   // No emission while waiting for a new transaction.
   `JPP_ASSERT_NOW(a_idle_quiet, clock, reset, req_tready, !cmd.emit, "emission while idle")
   // After the last result of a transaction the sequencer is ready again.
   `JPP_ASSERT_NEXT(a_last_to_idle, clock, reset, cmd.emit && cmd.last, req_tready, "not idle after last result")

endmodule

/* tb/tb_json_pretty_printer.sv */
// Self-checking testbench for the streaming JSON pretty printer.
`timescale 1ns / 1ps

module tb_json_pretty_printer;
   import jpp_pkg::*;

   localparam int NEST_LIMIT   = 15;    // nesting depth at which openers saturate
   localparam int RANDOM_ITEMS = 430;   // rough size of the random part
   localparam int HOLD_AT      = 120;   // accepted transactions before the long stall
   localparam int HOLD_CYCLES  = 400;   // length of the long receiver stall
   localparam int DRAIN_CYCLES = 64;    // settle time once nothing is expected

   // Class of the last byte written to the output, used by closers.
   typedef enum logic [1:0] {
      EMIT_NONE    = 2'd0,
      EMIT_NEWLINE = 2'd1,
      EMIT_SPACE   = 2'd2,
      EMIT_OTHER   = 2'd3
   } emit_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       start;
      logic       stop;
   } json_byte_type;

   typedef struct {
      logic [7:0] data;
      logic       ovf;
      logic       last;
   } out_beat_type;

   // Re-indenting predictor plus the store of formatted bytes still owed by the block.
   class reindent_scoreboard_type;
      logic          in_str;
      logic          escaped;
      logic [3:0]    nest;
      logic [4:0]    pend_spaces;
      emit_kind_type last_kind;
      logic          ovf_seen;
      logic [7:0]    run_bytes[$];
      out_beat_type  expected_out[$];
      int            mismatches;
      int            accepted;

      function new();
         clear_state();
         mismatches = 0;
         accepted   = 0;
      endfunction

      function void clear_state();
         in_str      = 1'b0;
         escaped     = 1'b0;
         nest        = '0;
         pend_spaces = '0;
         last_kind   = EMIT_NONE;
         ovf_seen    = 1'b0;
      endfunction

      function void emit(logic [7:0] b);
         run_bytes.insert(run_bytes.size(), b);
         if (b == CHAR_NEWLINE)
            last_kind = EMIT_NEWLINE;
         else if (b == CHAR_SPACE)
            last_kind = EMIT_SPACE;
         else
            last_kind = EMIT_OTHER;
      endfunction

      function void flush_spaces();
         while (pend_spaces != 0) begin
            emit(CHAR_SPACE);
            pend_spaces--;
         end
      endfunction

      // Work out the formatted bytes caused by one accepted input byte.
      function void note_req(logic [7:0] b, logic start, logic stop);
         out_beat_type beat;
         accepted++;
         run_bytes.delete();
         if (start)
            clear_state();
         if (in_str) begin
            flush_spaces();
            emit(b);
            if (escaped)
               escaped = 1'b0;
            else if (b == CHAR_BACKSLASH)
               escaped = 1'b1;
            else if (b == CHAR_QUOTE)
               in_str = 1'b0;
         end else if (b == CHAR_QUOTE) begin
            flush_spaces();
            emit(b);
            in_str  = 1'b1;
            escaped = 1'b0;
         end else if (b == CHAR_LBRACE || b == CHAR_LBRACKET) begin
            flush_spaces();
            emit(b);
            emit(CHAR_NEWLINE);
            if (nest >= NEST_LIMIT) begin
               nest     = 4'(NEST_LIMIT);
               ovf_seen = 1'b1;
            end else begin
               nest++;
            end
            pend_spaces = {nest, 1'b0};
         end else if (b == CHAR_RBRACE || b == CHAR_RBRACKET) begin
            // Drop pending spaces; a space already out cannot be withdrawn.
            pend_spaces = '0;
            if (last_kind != EMIT_NONE && last_kind != EMIT_NEWLINE)
               emit(CHAR_NEWLINE);
            if (nest != 0)
               nest--;
            repeat ({nest, 1'b0}) emit(CHAR_SPACE);
            emit(b);
         end else if (b == CHAR_COMMA) begin
            flush_spaces();
            emit(b);
            emit(CHAR_NEWLINE);
            pend_spaces = {nest, 1'b0};
         end else if (b == CHAR_COLON) begin
            flush_spaces();
            emit(b);
            pend_spaces = 5'd1;
         end else if (!(b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR))) begin
            flush_spaces();
            emit(b);
         end
         if (stop)
            flush_spaces();
         foreach (run_bytes[i]) begin
            beat.data = run_bytes[i];
            beat.ovf  = ovf_seen;
            beat.last = (i == run_bytes.size() - 1);
            expected_out.insert(expected_out.size(), beat);
         end
      endfunction

      function void flag_mismatch(string what, out_beat_type want, logic [7:0] data,
                                  logic ovf, logic last);
         mismatches++;
         if (mismatches <= 10)
            $display(
               "%0t mismatch, %s: expected %02h ovf %0b last %0b, got %02h ovf %0b last %0b",
               $time, what, want.data, want.ovf, want.last, data, ovf, last);
      endfunction

      // Compare one accepted result transaction with the oldest owed byte.
      function void check_rsp(logic [7:0] data, logic ovf, logic last);
         out_beat_type want;
         if (expected_out.size() == 0) begin
            want = '{data: '0, ovf: 1'b0, last: 1'b0};
            flag_mismatch("no byte owed", want, data, ovf, last);
         end else begin
            want = expected_out.pop_front();
            if (want.data !== data || want.ovf !== ovf || want.last !== last)
               flag_mismatch("wrong field", want, data, ovf, last);
         end
      endfunction
   endclass

   // Clock, reset and block ports; every input holds a known value from time zero.
   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // [7:0] in_byte
   logic       req_tuser  = 1'b0; // [0] chunk_start
   logic       req_tlast  = 1'b0; // chunk_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] out_byte
   logic       rsp_tuser;         // [0] depth_overflow
   logic       rsp_tlast;         // run_last

   reindent_scoreboard_type sb;
   json_byte_type           stim_q[$];

   // Receiver state
   int unsigned pat_cnt   = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   bit          ready_now;

   json_pretty_printer #(
      .MAX_DEPTH (NEST_LIMIT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the rising edge; note the input first so that its
   // expectations are in place before any result is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_req(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready)
            sb.check_rsp(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Receiver: cycle through stall patterns of its own, and once hold off for a
   // long stretch so that the block fills up and has to stall its input.
   always @(negedge clock) begin
      if (!hold_done && sb != null && sb.accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         pat_cnt++;
         case ((pat_cnt / 48) % 5)
            0:       ready_now = 1'b1;                        // no stalls at all
            1:       ready_now = ($urandom_range(0, 3) != 0);  // light random stalls
            2:       ready_now = (pat_cnt % 3 != 0);           // regular one-in-three
            3:       ready_now = ($urandom_range(0, 3) == 0);  // heavy stalls
            default: ready_now = (pat_cnt % 7 < 5);
         endcase
         rsp_tready <= ready_now;
      end
   end

   function automatic void add_byte(logic [7:0] b, logic start = 1'b0, logic stop = 1'b0);
      json_byte_type item;
      item.data  = b;
      item.start = start;
      item.stop  = stop;
      stim_q.insert(stim_q.size(), item);
   endfunction

   // Insert a little whitespace now and then, from the full set of blanks.
   function automatic void add_blanks();
      logic [7:0] blanks[6] = '{CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE, CHAR_CR, 8'h0B, 8'h0C};
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 2)) add_byte(blanks[$urandom_range(0, 5)]);
   endfunction

   // String literal with random content, escapes included.
   function automatic void add_string();
      logic [7:0] c;
      add_byte(CHAR_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         c = 8'($urandom_range(0, 255));
         if (c == CHAR_QUOTE || c == CHAR_BACKSLASH || $urandom_range(0, 5) == 0)
            add_byte(CHAR_BACKSLASH);
         add_byte(c);
      end
      add_byte(CHAR_QUOTE);
   endfunction

   function automatic void add_value();
      string scalar_chars = "0123456789-+.eEtrufalsn";
      if ($urandom_range(0, 1) == 0) begin
         add_string();
      end else begin
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 15) == 0)
               add_byte(8'($urandom_range(128, 255)));
            else
               add_byte(scalar_chars[$urandom_range(0, scalar_chars.len() - 1)]);
         end
      end
   endfunction

   // Mostly well-formed document with random content; a deep one nests past the limit.
   function automatic void gen_doc(bit go_deep);
      logic [7:0] closers[$];
      int         budget;
      int         first;
      bit         need_elem;
      bit         just_opened;
      first  = stim_q.size();
      budget = go_deep ? $urandom_range(20, 40) : $urandom_range(6, 30);
      add_blanks();
      if ($urandom_range(0, 1) == 0) begin
         add_byte(CHAR_LBRACE);
         closers.insert(closers.size(), CHAR_RBRACE);
      end else begin
         add_byte(CHAR_LBRACKET);
         closers.insert(closers.size(), CHAR_RBRACKET);
      end
      need_elem   = 1'b1;
      just_opened = 1'b1;
      while (closers.size() != 0) begin
         add_blanks();
         if (need_elem && just_opened && $urandom_range(0, 7) == 0) begin
            // Empty container
            add_byte(closers[$]);
            closers.delete(closers.size() - 1);
            need_elem = 1'b0;
         end else if (need_elem) begin
            if (closers[$] == CHAR_RBRACE) begin
               add_string();
               add_blanks();
               add_byte(CHAR_COLON);
               add_blanks();
            end
            if (budget > 0 && closers.size() < 20 &&
                ((go_deep && closers.size() < NEST_LIMIT + 2) || $urandom_range(0, 3) == 0)) begin
               if ($urandom_range(0, 1) == 0) begin
                  add_byte(CHAR_LBRACE);
                  closers.insert(closers.size(), CHAR_RBRACE);
               end else begin
                  add_byte(CHAR_LBRACKET);
                  closers.insert(closers.size(), CHAR_RBRACKET);
               end
               just_opened = 1'b1;
            end else begin
               add_value();
               need_elem   = 1'b0;
               just_opened = 1'b0;
            end
         end else if (budget > 0 && $urandom_range(0, 2) != 0) begin
            add_byte(CHAR_COMMA);
            need_elem   = 1'b1;
            just_opened = 1'b0;
         end else begin
            add_byte(closers[$]);
            closers.delete(closers.size() - 1);
         end
         budget--;
      end
      // Start the chunk on most documents; leave some to run on from the last one.
      stim_q[first].start = ($urandom_range(0, 9) != 0) || go_deep;
      for (int i = first; i < stim_q.size(); i++)
         if ($urandom_range(0, 29) == 0)
            stim_q[i].stop = 1'b1;
      stim_q[stim_q.size() - 1].stop = ($urandom_range(0, 9) != 0);
   endfunction

   // Random bytes with random chunk flags.
   function automatic void gen_noise();
      int first;
      first = stim_q.size();
      repeat ($urandom_range(4, 16))
         add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                  $urandom_range(0, 7) == 0);
      stim_q[first].start = 1'($urandom_range(0, 1));
   endfunction

   // Offer one transaction from a falling edge and hold it until it is taken.
   task automatic send_item(json_byte_type item);
      req_tvalid <= 1'b1;
      req_tdata  <= item.data;
      req_tuser  <= item.start;
      req_tlast  <= item.stop;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int idx;
      int burst;
      int gap;
      sb = new();

      // Directed part: closer before any output at depth zero, strings with
      // escapes, every structural byte, blanks, high and zero bytes, a flush at
      // chunk end followed by a closer without a chunk start.
      add_byte(CHAR_RBRACE, 1'b1);
      add_byte(CHAR_LBRACE);
      add_byte(CHAR_QUOTE);
      add_byte("k");
      add_byte(CHAR_BACKSLASH);
      add_byte(CHAR_QUOTE);
      add_byte(CHAR_QUOTE);
      add_byte(CHAR_SPACE);
      add_byte(CHAR_COLON);
      add_byte(CHAR_TAB);
      add_byte(8'hE9);
      add_byte(CHAR_COMMA, 1'b0, 1'b1);
      add_byte(CHAR_RBRACKET);
      add_byte(CHAR_RBRACKET);
      add_byte(CHAR_LBRACKET, 1'b1);
      add_byte(CHAR_RBRACKET);
      add_byte(CHAR_CR);
      add_byte(8'h0B);
      add_byte(8'h0C);
      add_byte(CHAR_NEWLINE);
      add_byte(8'hFF);
      add_byte(8'h00);
      add_byte(CHAR_QUOTE);
      add_byte(CHAR_NEWLINE);
      add_byte(8'h80);
      add_byte(CHAR_QUOTE, 1'b0, 1'b1);

      // Random part: open with a document that overflows the nesting limit.
      idx = stim_q.size();
      gen_doc(1'b1);
      while (stim_q.size() < idx + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1:    gen_noise();
            2:       gen_doc(1'b1);
            default: gen_doc(1'b0);
         endcase
      end

      // Hold reset, then release it at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Send in bursts of random length with random gaps, some gapless stretches.
      idx = 0;
      while (idx < stim_q.size()) begin
         burst = $urandom_range(1, 16);
         while (burst != 0 && idx < stim_q.size()) begin
            send_item(stim_q[idx]);
            idx++;
            burst--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
         if (gap != 0 && idx < stim_q.size()) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every owed byte, then let the block settle.
      while (sb.expected_out.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_out.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
